FILE: hdl/hrd_pkg.sv
package hrd_pkg;

  localparam int unsigned PHASE_W = 3;
  localparam int unsigned ALEFT_W = 3;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CNT_W   = 32;

  localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
  localparam logic [7:0] LONG_ADDR_BIT = 8'h80;
  localparam logic [ALEFT_W-1:0] LONG_ADDR_LEN  = 3'd5;
  localparam logic [ALEFT_W-1:0] SHORT_ADDR_LEN = 3'd1;

  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_CLOSE = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_RESP  = 3'd1;
  localparam logic [STAT_W-1:0] ST_TRUNC    = 3'd2;
  localparam logic [STAT_W-1:0] ST_CHECKSUM = 3'd3;
  localparam logic [STAT_W-1:0] ST_SHORT    = 3'd4;
  localparam logic [STAT_W-1:0] ST_COMM     = 3'd5;

endpackage

FILE: hdl/hart_response_deframer.sv
// HART response deframer. Each input beat is either one received byte or the
// end-of-reception event; the block sustains one beat per cycle while its result
// register is not held by a stalled out_ready. The parser state updates as the beat is taken
// and the beat's result, if any, lands in a single output register the cycle
// after. in_ready is high whenever that register is empty or is being read in
// the same cycle, so input is held back only while a result waits on a stalled
// out_ready. Payload beats (kind 0) are tentative and may be followed by an
// error status; exactly one status beat (kind 1) closes each frame.
module hart_response_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [7:0]                  out_payload_byte,
  output logic [7:0]                  out_payload_index,
  output logic [hrd_pkg::STAT_W-1:0]  out_status,
  output logic [7:0]                  out_response_code,
  output logic [7:0]                  out_device_status,
  output logic [7:0]                  out_payload_length,
  output logic [hrd_pkg::CNT_W-1:0]   out_good_count,
  output logic [hrd_pkg::CNT_W-1:0]   out_error_count
);

  localparam logic [hrd_pkg::PHASE_W-1:0] PH_PREAMBLE = 3'd0;
  localparam logic [hrd_pkg::PHASE_W-1:0] PH_ADDRESS  = 3'd1;
  localparam logic [hrd_pkg::PHASE_W-1:0] PH_COMMAND  = 3'd2;
  localparam logic [hrd_pkg::PHASE_W-1:0] PH_COUNT    = 3'd3;
  localparam logic [hrd_pkg::PHASE_W-1:0] PH_DATA     = 3'd4;
  localparam logic [hrd_pkg::PHASE_W-1:0] PH_CHECK    = 3'd5;
  localparam logic [hrd_pkg::PHASE_W-1:0] PH_DONE     = 3'd6;

  logic [hrd_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [hrd_pkg::ALEFT_W-1:0] aleft_r, aleft_nxt;
  logic [7:0]                  bcount_r, bcount_nxt;
  logic [7:0]                  didx_r, didx_nxt;
  logic [7:0]                  xor_r, xor_nxt;
  logic [7:0]                  rcode_r, rcode_nxt;
  logic [7:0]                  dstat_r, dstat_nxt;
  logic                        seen_r, seen_nxt;
  logic [hrd_pkg::CNT_W-1:0]   good_r, good_nxt;
  logic [hrd_pkg::CNT_W-1:0]   err_r, err_nxt;

  logic                        ovalid_r;
  logic                        okind_r, okind_nxt;
  logic [7:0]                  obyte_r, obyte_nxt;
  logic [7:0]                  oidx_r, oidx_nxt;
  logic [hrd_pkg::STAT_W-1:0]  ostat_r, ostat_nxt;
  logic [7:0]                  orcode_r, orcode_nxt;
  logic [7:0]                  odstat_r, odstat_nxt;
  logic [7:0]                  olen_r, olen_nxt;

  logic                        in_fire;
  logic                        emit;
  logic [7:0]                  didx_inc;

  assign in_ready = !ovalid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign didx_inc = didx_r + 8'd1;

  always_comb begin
    phase_nxt  = phase_r;
    aleft_nxt  = aleft_r;
    bcount_nxt = bcount_r;
    didx_nxt   = didx_r;
    xor_nxt    = xor_r;
    rcode_nxt  = rcode_r;
    dstat_nxt  = dstat_r;
    seen_nxt   = seen_r;
    good_nxt   = good_r;
    err_nxt    = err_r;
    emit       = 1'b0;
    okind_nxt  = hrd_pkg::KIND_STATUS;
    obyte_nxt  = 8'd0;
    oidx_nxt   = 8'd0;
    ostat_nxt  = hrd_pkg::ST_OK;
    olen_nxt   = 8'd0;
    orcode_nxt = rcode_r;
    odstat_nxt = dstat_r;
    if (in_action == hrd_pkg::ACT_CLOSE) begin
      if (phase_r != PH_DONE) begin
        emit      = 1'b1;
        err_nxt   = err_r + 1'b1;
        ostat_nxt = seen_r ? hrd_pkg::ST_TRUNC : hrd_pkg::ST_NO_RESP;
      end
      phase_nxt  = PH_PREAMBLE;
      aleft_nxt  = '0;
      bcount_nxt = 8'd0;
      didx_nxt   = 8'd0;
      xor_nxt    = 8'd0;
      rcode_nxt  = 8'd0;
      dstat_nxt  = 8'd0;
      seen_nxt   = 1'b0;
    end else begin
      case (phase_r)
        PH_PREAMBLE: begin
          seen_nxt = 1'b1;
          if (in_rx_byte != hrd_pkg::PREAMBLE_BYTE) begin
            xor_nxt   = in_rx_byte;
            aleft_nxt = ((in_rx_byte & hrd_pkg::LONG_ADDR_BIT) != 8'd0) ?
                        hrd_pkg::LONG_ADDR_LEN : hrd_pkg::SHORT_ADDR_LEN;
            phase_nxt = PH_ADDRESS;
          end
        end
        PH_ADDRESS: begin
          xor_nxt   = xor_r ^ in_rx_byte;
          aleft_nxt = aleft_r - 1'b1;
          if (aleft_r == hrd_pkg::SHORT_ADDR_LEN) begin
            phase_nxt = PH_COMMAND;
          end
        end
        PH_COMMAND: begin
          xor_nxt   = xor_r ^ in_rx_byte;
          phase_nxt = PH_COUNT;
        end
        PH_COUNT: begin
          xor_nxt    = xor_r ^ in_rx_byte;
          bcount_nxt = in_rx_byte;
          didx_nxt   = 8'd0;
          phase_nxt  = (in_rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          xor_nxt = xor_r ^ in_rx_byte;
          if (didx_r == 8'd0) begin
            rcode_nxt = in_rx_byte;
          end else if (didx_r == 8'd1) begin
            dstat_nxt = in_rx_byte;
          end else begin
            emit      = 1'b1;
            okind_nxt = hrd_pkg::KIND_PAYLOAD;
            obyte_nxt = in_rx_byte;
            oidx_nxt  = didx_r - 8'd2;
          end
          didx_nxt = didx_inc;
          if (didx_inc == bcount_r) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_nxt = PH_DONE;
          emit      = 1'b1;
          if (xor_r != in_rx_byte) begin
            err_nxt   = err_r + 1'b1;
            ostat_nxt = hrd_pkg::ST_CHECKSUM;
          end else if (bcount_r < 8'd2) begin
            err_nxt   = err_r + 1'b1;
            ostat_nxt = hrd_pkg::ST_SHORT;
          end else if ((rcode_r & hrd_pkg::LONG_ADDR_BIT) != 8'd0) begin
            err_nxt   = err_r + 1'b1;
            ostat_nxt = hrd_pkg::ST_COMM;
          end else begin
            good_nxt = good_r + 1'b1;
            olen_nxt = bcount_r - 8'd2;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREAMBLE;
      aleft_r  <= '0;
      bcount_r <= 8'd0;
      didx_r   <= 8'd0;
      xor_r    <= 8'd0;
      rcode_r  <= 8'd0;
      dstat_r  <= 8'd0;
      seen_r   <= 1'b0;
      good_r   <= '0;
      err_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r  <= phase_nxt;
        aleft_r  <= aleft_nxt;
        bcount_r <= bcount_nxt;
        didx_r   <= didx_nxt;
        xor_r    <= xor_nxt;
        rcode_r  <= rcode_nxt;
        dstat_r  <= dstat_nxt;
        seen_r   <= seen_nxt;
        good_r   <= good_nxt;
        err_r    <= err_nxt;
        ovalid_r <= emit;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // result beat payload, loaded only when a result is produced
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      okind_r  <= okind_nxt;
      obyte_r  <= obyte_nxt;
      oidx_r   <= oidx_nxt;
      ostat_r  <= ostat_nxt;
      orcode_r <= orcode_nxt;
      odstat_r <= odstat_nxt;
      olen_r   <= olen_nxt;
    end
  end

  assign out_valid          = ovalid_r;
  assign out_kind           = okind_r;
  assign out_payload_byte   = obyte_r;
  assign out_payload_index  = oidx_r;
  assign out_status         = ostat_r;
  assign out_response_code  = orcode_r;
  assign out_device_status  = odstat_r;
  assign out_payload_length = olen_r;
  assign out_good_count     = good_r;
  assign out_error_count    = err_r;

endmodule
